// ===== rtl/shimgr_pkg.sv =====
// Shared interrupt line manager: types, codes and constants.
`default_nettype none

package shimgr_pkg;

  localparam int LINE_COUNT = 16;
  localparam int SLOT_COUNT = 32;
  localparam int LINE_IW    = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  localparam logic [31:0] SLOT_SPACE = 32'((64'd1 << SLOT_COUNT) - 64'd1);

  // report interval is 25 << gap_exp: 100 after reset, doubling stops at 25 << 26
  localparam logic [4:0] GAP_EXP_RESET = 5'd2;
  localparam logic [4:0] GAP_EXP_MAX   = 5'd26;

  localparam int IN_W  = 48;
  localparam int OUT_W = 80;

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_HANDLE   = 3'd2,
    ACT_ENABLE   = 3'd3,
    ACT_DISABLE  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LINE = 2'd1,
    STATUS_NO_SLOT  = 2'd2,
    STATUS_SPURIOUS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [31:0] used;
    logic [31:0] active;
    logic        masked;
    logic        in_use;
    logic [31:0] spur;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{used: '0, active: '0, masked: 1'b1,
                                     in_use: 1'b0, spur: '0};

  typedef struct packed {
    status_e     status;
    logic [4:0]  assigned;
    logic [31:0] call_mask;
    logic        masked;
    logic        in_use;
    logic        ack;
    logic        was_en;
    logic [31:0] spur_total;
    logic        report;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/shared_irq_line_manager_unit.sv =====
// Shared interrupt line manager: per-line slot table with read-modify-write.
//
// Input stream (s_axis): one action per transaction: register, remove,
// handle, enable or disable on one interrupt line. Output stream (m_axis):
// exactly one result transaction per input transaction, in order.
// Line state (used and active slot masks, mask bit, in-use bit, spurious
// count) is held in a line-indexed synchronous RAM, one entry per line;
// a valid bit per entry makes unwritten entries read as their reset value.
// An action runs in steps: RAM read, update, then the report check for
// spurious counts (the first count, or divisibility by the shared interval)
// with write-back and output load. The next action is taken only once the
// previous one has written back, so actions do not overlap; tvalid rises
// when the output register is loaded in the final step.
// The output register lets a new action be accepted while a result waits;
// if the receiver stalls, the following action is held in its final stage
// until the output register frees up.
// Reset clears all entry valid bits (lines masked, unused, zero counts) and
// sets the report interval to 100; the block is ready in the first cycle.
`default_nettype none

module shared_irq_line_manager_unit import shimgr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // action[2:0], line[7:3], handler_slot[12:8], done_mask[44:13], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // status[1:0], assigned_slot[6:2], call_mask[38:7], line_masked[39],
  // line_in_use[40], acknowledge[41], was_enabled[42], spurious_total[74:43],
  // report_spurious[75], zero pad
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  state_e state_q, state_d;

  logic              in_acc;
  logic              fin;
  logic [LINE_IW-1:0] in_idx;

  logic [2:0]  action_q;
  logic [4:0]  line_q;
  logic [4:0]  slot_q;
  logic [31:0] done_q;
  logic        line_ok_q;

  entry_t      mem_q [LINE_COUNT];
  entry_t      rd_q;
  logic [LINE_COUNT-1:0] entry_vld_q;
  logic        rd_vld_q;

  entry_t      n_d, n_q;
  result_t     res_d, res_q;
  logic        chk_d, chk_q;
  logic        wr_d, wr_q;
  logic [11:0] v_d, v_q;

  logic [4:0]  gap_exp_q;
  logic [22:0] prod;
  logic [7:0]  quo;
  logic [11:0] rem;
  logic [31:0] low_mask;
  logic        report;

  result_t     out_q;
  logic        out_vld_q;

  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;
  assign in_idx = s_axis_tdata_i[3 +: LINE_IW];

  // control
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    fin             = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) state_d = S_CALC;
      end
      S_CALC: state_d = S_FINISH;
      S_FINISH: begin
        if (!out_vld_q || m_axis_tready_i) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      chk_q       <= 1'b0;
      wr_q        <= 1'b0;
      gap_exp_q   <= GAP_EXP_RESET;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) rd_vld_q <= entry_vld_q[in_idx];
      if (state_q == S_CALC) begin
        chk_q <= chk_d;
        wr_q  <= wr_d;
      end
      if (fin && wr_q) entry_vld_q[line_q[LINE_IW-1:0]] <= 1'b1;
      if (fin && report && gap_exp_q < GAP_EXP_MAX) gap_exp_q <= gap_exp_q + 5'd1;
      if (fin) out_vld_q <= 1'b1;
      else if (m_axis_tready_i) out_vld_q <= 1'b0;
    end
  end

  // line table
  always_ff @(posedge clk_i) begin
    if (in_acc) rd_q <= mem_q[in_idx];
    if (fin && wr_q) mem_q[line_q[LINE_IW-1:0]] <= n_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q  <= s_axis_tdata_i[2:0];
      line_q    <= s_axis_tdata_i[7:3];
      slot_q    <= s_axis_tdata_i[12:8];
      done_q    <= s_axis_tdata_i[44:13];
      line_ok_q <= {1'b0, s_axis_tdata_i[7:3]} < 6'(LINE_COUNT);
    end
    if (state_q == S_CALC) begin
      n_q   <= n_d;
      res_q <= res_d;
      v_q   <= v_d;
    end
    if (fin) out_q <= '{status: res_q.status, assigned: res_q.assigned,
                        call_mask: res_q.call_mask, masked: res_q.masked,
                        in_use: res_q.in_use, ack: res_q.ack, was_en: res_q.was_en,
                        spur_total: res_q.spur_total, report: report};
  end

  // entry update
  always_comb begin
    entry_t      e;
    logic        slot_ok;
    logic [31:0] bit_m;
    logic [31:0] free_m;
    logic [4:0]  s;
    logic [31:0] c;

    e       = rd_vld_q ? rd_q : ENTRY_RESET;
    n_d     = e;
    res_d   = '0;
    chk_d   = 1'b0;
    wr_d    = line_ok_q;
    slot_ok = {1'b0, slot_q} < 6'(SLOT_COUNT);
    bit_m   = slot_ok ? (32'd1 << slot_q) : 32'd0;
    free_m  = ~e.used & SLOT_SPACE;
    s       = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_m[i]) s = 5'(i);
    end

    case (action_q)
      ACT_REGISTER: begin
        if (free_m == '0) begin
          res_d.status = STATUS_NO_SLOT;
        end else begin
          res_d.assigned = s;
          n_d.used       = e.used | (32'd1 << s);
          n_d.active     = e.active & ~(32'd1 << s);
          if (n_d.active == '0) begin
            n_d.in_use = 1'b1;
            n_d.masked = 1'b0;
          end
        end
      end
      ACT_REMOVE: begin
        if (slot_ok) begin
          n_d.used   = e.used & ~bit_m;
          n_d.active = e.active & ~bit_m;
          if (n_d.used == '0) begin
            n_d.masked = 1'b1;
            n_d.in_use = 1'b0;
          end else if (n_d.active == '0) begin
            n_d.masked = 1'b0;
          end
        end
      end
      ACT_HANDLE: begin
        n_d.masked = 1'b1;
        if (e.used == '0) begin
          res_d.status = STATUS_SPURIOUS;
          if (e.spur != '1) begin
            n_d.spur = e.spur + 32'd1;
            chk_d    = 1'b1;
          end
        end else begin
          res_d.call_mask = e.used;
          res_d.ack       = 1'b1;
          n_d.active      = (e.active | e.used) & ~(e.used & done_q);
          if (n_d.active == '0) n_d.masked = 1'b0;
        end
      end
      ACT_ENABLE: begin
        if (slot_ok) begin
          n_d.active = e.active & ~bit_m;
          if (n_d.active == '0) n_d.masked = 1'b0;
        end
      end
      ACT_DISABLE: begin
        if (slot_ok && (e.active & bit_m) == '0) begin
          n_d.active   = e.active | bit_m;
          n_d.masked   = 1'b1;
          res_d.was_en = 1'b1;
        end
      end
      default: ;
    endcase

    res_d.masked     = n_d.masked;
    res_d.in_use     = n_d.in_use;
    res_d.spur_total = n_d.spur;

    if (!line_ok_q) begin
      res_d        = '0;
      res_d.status = STATUS_BAD_LINE;
      chk_d        = 1'b0;
    end

    // 1024 = -1 mod 25: alternating sum of 10-bit chunks, offset by 42 * 25
    c   = n_d.spur;
    v_d = 12'd1050 + 12'(c[9:0]) + 12'(c[29:20]) - 12'(c[19:10]) - 12'(c[31:30]);
  end

  // report check: count equal to one, or divisible by 25 << gap_exp
  assign prod     = 23'(v_q) * 23'd1311;
  assign quo      = prod[22:15];
  assign rem      = v_q - (12'(quo) << 4) - (12'(quo) << 3) - 12'(quo);
  assign low_mask = (32'd1 << gap_exp_q) - 32'd1;
  assign report   = chk_q & ((res_q.spur_total == 32'd1) |
                    (((res_q.spur_total & low_mask) == '0) & (rem == '0)));

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_q.report, out_q.spur_total, out_q.was_en,
                            out_q.ack, out_q.in_use, out_q.masked, out_q.call_mask,
                            out_q.assigned, out_q.status};

endmodule

`default_nettype wire

// ===== rtl/shimgr_checker.sv =====
// Shared interrupt line manager: port-level checks and their binding.
`default_nettype none

module shimgr_checker import shimgr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [IN_W-1:0]  s_axis_tdata_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  logic in_acc;
  assign in_acc = s_axis_tvalid_i & s_axis_tready_o;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input taken while previous transaction in flight");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(in_acc, 3))
    else $error("result without matching input transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_bad_line_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] == STATUS_BAD_LINE
      |-> m_axis_tdata_o[75:2] == '0)
    else $error("invalid line result carries data");

  a_ack_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[41]
      |-> m_axis_tdata_o[1:0] == STATUS_OK && m_axis_tdata_o[38:7] != '0)
    else $error("acknowledge without handlers");

endmodule

bind shared_irq_line_manager_unit shimgr_checker u_shimgr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

// ===== dv/shared_irq_line_manager_unit_tb.sv =====
// Self-checking testbench: stream stimulus and line-table scoreboard for the shared IRQ manager.
`timescale 1ns / 100ps

module shared_irq_line_manager_unit_tb;
  import shimgr_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int N_ITEMS        = 1300;
  localparam int PRINT_CAP      = 100;

  localparam logic [31:0] GAP_START = 32'd100;
  localparam logic [31:0] GAP_CAP   = 32'h3FFF_FFFF;

  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [31:0] done;
    logic [4:0]  slot;
    logic [4:0]  line;
    logic [2:0]  action;
  } action_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic        report;
    logic [31:0] spur;
    logic        was_en;
    logic        ack;
    logic        in_use;
    logic        masked;
    logic [31:0] calls;
    logic [4:0]  assigned;
    logic [1:0]  status;
  } result_rec_t;

  class line_table_model;
    logic [31:0] used [LINE_COUNT];
    logic [31:0] active [LINE_COUNT];
    logic        masked [LINE_COUNT];
    logic        in_use [LINE_COUNT];
    logic [31:0] spur [LINE_COUNT];
    logic [31:0] gap;
    result_rec_t pending [$];
    int errors, n_in, n_out, n_spur, n_report, n_full, n_bad;

    function new();
      for (int i = 0; i < LINE_COUNT; i++) begin
        used[i]   = '0;
        active[i] = '0;
        masked[i] = 1'b1;
        in_use[i] = 1'b0;
        spur[i]   = '0;
      end
      gap = GAP_START;
    endfunction

    task flag(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("ERROR %0t: %s", $time, msg);
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function void take_action(action_t it);
      result_rec_t r;
      int ln, s;
      logic [31:0] bit_m, free_m, c;
      r = '0;
      n_in++;
      ln = int'(it.line);
      if (ln >= LINE_COUNT) begin
        r.status = STATUS_BAD_LINE;
        n_bad++;
        pending.push_back(r);
        return;
      end
      bit_m = (it.slot < SLOT_COUNT) ? (32'd1 << it.slot) : '0;
      case (it.action)
        ACT_REGISTER: begin
          free_m = ~used[ln] & SLOT_SPACE;
          if (free_m == '0) begin
            r.status = STATUS_NO_SLOT;
            n_full++;
          end else begin
            s = 0;
            while (!free_m[s]) s++;
            r.assigned = 5'(s);
            bit_m = 32'd1 << s;
            used[ln]   |= bit_m;
            active[ln] &= ~bit_m;
            if (active[ln] == '0) begin
              in_use[ln] = 1'b1;
              masked[ln] = 1'b0;
            end
          end
        end
        ACT_REMOVE: if (bit_m != '0) begin
          used[ln]   &= ~bit_m;
          active[ln] &= ~bit_m;
          if (used[ln] == '0) begin
            masked[ln] = 1'b1;
            in_use[ln] = 1'b0;
          end else if (active[ln] == '0) begin
            masked[ln] = 1'b0;
          end
        end
        ACT_HANDLE: begin
          masked[ln] = 1'b1;
          if (used[ln] == '0) begin
            r.status = STATUS_SPURIOUS;
            n_spur++;
            if (spur[ln] != '1) begin
              c = spur[ln] + 32'd1;
              spur[ln] = c;
              if (c == 32'd1 || (c % gap) == '0) begin
                r.report = 1'b1;
                n_report++;
                if (gap < GAP_CAP) gap = gap * 2;
              end
            end
          end else begin
            r.calls = used[ln];
            active[ln] = (active[ln] | used[ln]) & ~(used[ln] & it.done);
            if (active[ln] == '0) masked[ln] = 1'b0;
            r.ack = 1'b1;
          end
        end
        ACT_ENABLE: if (bit_m != '0) begin
          active[ln] &= ~bit_m;
          if (active[ln] == '0) masked[ln] = 1'b0;
        end
        ACT_DISABLE: if (bit_m != '0 && (active[ln] & bit_m) == '0) begin
          active[ln] |= bit_m;
          masked[ln] = 1'b1;
          r.was_en = 1'b1;
        end
        default: ;
      endcase
      r.masked = masked[ln];
      r.in_use = in_use[ln];
      r.spur   = spur[ln];
      pending.push_back(r);
    endfunction

    task check_result(result_rec_t got);
      result_rec_t want;
      n_out++;
      if (pending.size() == 0) begin
        flag("result transaction with no action pending");
        return;
      end
      want = pending.pop_front();
      cmp("status", 32'(got.status), 32'(want.status));
      cmp("assigned_slot", 32'(got.assigned), 32'(want.assigned));
      cmp("call_mask", got.calls, want.calls);
      cmp("line_masked", 32'(got.masked), 32'(want.masked));
      cmp("line_in_use", 32'(got.in_use), 32'(want.in_use));
      cmp("acknowledge", 32'(got.ack), 32'(want.ack));
      cmp("was_enabled", 32'(got.was_en), 32'(want.was_en));
      cmp("spurious_total", got.spur, want.spur);
      cmp("report_spurious", 32'(got.report), 32'(want.report));
      cmp("pad", 32'(got.pad), 32'(want.pad));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tready = 1'b0;
  logic             s_axis_tready;
  logic             m_axis_tvalid;
  logic [OUT_W-1:0] m_axis_tdata;

  line_table_model tbl = new();
  bit calm = 1'b0;
  bit hold_rx = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  shared_irq_line_manager_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) tbl.check_result(result_rec_t'(m_axis_tdata));
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", idle_cycles);
        $display("shared_irq_line_manager_unit: mismatch");
        $finish;
      end
    end
  end

  function automatic int rand_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic int rand_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // receiver: random back-pressure, long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_rx = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = rand_stall() - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send(action_t it);
    int g;
    g = rand_gap();
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(it);
    do @(posedge clk_i); while (!s_axis_tready);
    tbl.take_action(it);
  endtask

  task automatic act(logic [2:0] a, logic [4:0] ln, logic [4:0] sl, logic [31:0] dn);
    action_t it;
    it.action = a;
    it.line   = ln;
    it.slot   = sl;
    it.done   = dn;
    send(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tbl.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [4:0] pick_slot(int ln);
    logic [31:0] u;
    int s;
    u = tbl.used[ln];
    if (u != '0 && $urandom_range(0, 3) != 0) begin
      do s = $urandom_range(0, SLOT_COUNT - 1); while (!u[s]);
      return 5'(s);
    end
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] rand_done();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic mixed(int n, int focus);
    int ln, r;
    logic [2:0] a;
    repeat (n) begin
      if (focus >= 0 && $urandom_range(0, 9) < 7) ln = focus;
      else if ($urandom_range(0, 19) == 0) ln = $urandom_range(LINE_COUNT, 31);
      else ln = $urandom_range(0, LINE_COUNT - 1);
      r = $urandom_range(0, 99);
      if (r < 20) a = ACT_REGISTER;
      else if (r < 35) a = ACT_REMOVE;
      else if (r < 65) a = ACT_HANDLE;
      else if (r < 80) a = ACT_ENABLE;
      else if (r < 97) a = ACT_DISABLE;
      else a = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
      act(a, 5'(ln), (ln < LINE_COUNT) ? pick_slot(ln) : 5'($urandom_range(0, 31)),
          rand_done());
    end
  endtask

  // register until the line is full, then refusals, then traffic on it
  task automatic fill(int ln);
    while (tbl.used[ln] != SLOT_SPACE) begin
      act(ACT_REGISTER, 5'(ln), 5'($urandom_range(0, 31)), rand_done());
      if ($urandom_range(0, 4) == 0) act(ACT_HANDLE, 5'(ln), 5'($urandom_range(0, 31)), rand_done());
    end
    repeat (2) act(ACT_REGISTER, 5'(ln), 5'($urandom_range(0, 31)), rand_done());
    mixed(15, ln);
  endtask

  task automatic spur_burst(int n);
    int ln;
    do ln = $urandom_range(0, LINE_COUNT - 1); while (tbl.used[ln] != '0);
    repeat (n) act(ACT_HANDLE, 5'(ln), 5'($urandom_range(0, 31)), rand_done());
  endtask

  initial begin
    int chunk, focus;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed
    act(ACT_REGISTER, 5'd0, 5'd0, '0);
    act(ACT_REGISTER, 5'd0, 5'd0, '0);
    act(ACT_HANDLE,   5'd0, 5'd0, '0);
    act(ACT_ENABLE,   5'd0, 5'd1, '0);
    act(ACT_HANDLE,   5'd0, 5'd0, '1);
    act(ACT_DISABLE,  5'd0, 5'd1, '0);
    act(ACT_DISABLE,  5'd0, 5'd1, '0);
    act(ACT_REGISTER, 5'd0, 5'd31, '1);
    act(ACT_ENABLE,   5'd0, 5'd1, '0);
    act(ACT_HANDLE,   5'd0, 5'd0, 32'h0000_0005);
    act(ACT_REMOVE,   5'd0, 5'd1, '0);
    act(ACT_HANDLE,   5'd3, 5'd0, '0);
    act(ACT_HANDLE,   5'd3, 5'd31, '1);
    act(ACT_HANDLE,   5'd31, 5'd0, '1);
    act(ACT_REGISTER, 5'(LINE_COUNT), 5'd0, '0);
    act(ACT_DISABLE,  5'd31, 5'd31, '1);
    act(ACT_SPARE_5,  5'd0, 5'd0, '1);
    act(ACT_SPARE_6,  5'd0, 5'd2, '0);
    act(ACT_SPARE_7,  5'd15, 5'd31, '1);
    act(ACT_REMOVE,   5'd0, 5'd0, '0);
    act(ACT_REMOVE,   5'd0, 5'd2, '0);
    act(ACT_REMOVE,   5'd2, 5'd31, '1);
    act(ACT_ENABLE,   5'd15, 5'd31, '0);
    act(ACT_DISABLE,  5'd15, 5'd31, '0);
    act(ACT_HANDLE,   5'd15, 5'd31, '1);
    drain();

    spur_burst(200);

    chunk = 0;
    while (tbl.n_in < N_ITEMS) begin
      calm = (chunk % 6 == 4);
      case (chunk)
        2, 11, 19: fill($urandom_range(0, LINE_COUNT - 1));
        5, 16: begin
          calm = 1'b1;
          hold_rx = 1'b1;
          mixed(24, -1);
        end
        8, 22: begin
          mixed(30, -1);
          drain();
        end
        default: begin
          focus = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, LINE_COUNT - 1)) : -1;
          mixed($urandom_range(20, 50), focus);
        end
      endcase
      chunk++;
    end
    calm = 1'b0;
    drain();

    $display("Covered %0d actions and %0d results: %0d spurious (%0d reported), %0d refused",
             tbl.n_in, tbl.n_out, tbl.n_spur, tbl.n_report, tbl.n_full);
    $display("registrations on full lines, %0d invalid lines, %0d errors.", tbl.n_bad, tbl.errors);
    if (tbl.errors == 0 && tbl.pending.size() == 0) begin
      $display("shared_irq_line_manager_unit: match");
    end else begin
      $display("shared_irq_line_manager_unit: mismatch");
    end
    $finish;
  end

endmodule
